/* src/mcc_pkg.sv */
// package: shared constants, types and state encoding for the coin change block
`default_nettype none

package mcc_pkg;

    // field widths fixed by the interface
    localparam int COIN_W    = 10;
    localparam int CNT_CFG_W = 3;
    localparam int IDX_W     = 3;
    localparam int BEST_W    = 11;
    localparam int CFG_ADDR_W = 3;

    // number of denomination registers
    localparam int COIN_REGS = 6;

    // default sizing
    localparam int DEF_MAX_AMOUNT = 1023;
    localparam int DEF_NUM_COINS  = 6;

    // marker for an amount that cannot be made
    localparam logic [BEST_W-1:0] UNREACH = '1;

    // register indexes of the configuration port
    localparam logic [CFG_ADDR_W-1:0] REG_COIN_COUNT = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_COIN_FIRST = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_COIN_LAST  = 3'd6;

    // reset values of the configuration registers
    localparam logic [CNT_CFG_W-1:0] COIN_COUNT_RST = 3'd1;
    localparam logic [COIN_W-1:0]    COIN_VAL_RST   = 10'd1;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_INIT,
        ST_FILL,
        ST_WALK_RD,
        ST_WALK_EV,
        ST_OUT
    } state_t;

endpackage

`default_nettype wire

/* src/mcc_table.sv */
// single port table holding best coin count and last coin per amount
`default_nettype none

module mcc_table #(
    parameter int DEPTH = mcc_pkg::DEF_MAX_AMOUNT + 1,
    parameter int AW    = $clog2(DEPTH)
) (
    input  wire logic                        aclk,
    input  wire logic                        wr_en,
    input  wire logic [AW-1:0]               addr,
    input  wire logic [mcc_pkg::BEST_W-1:0]  wr_best,
    input  wire logic [mcc_pkg::IDX_W-1:0]   wr_last,
    output      logic [mcc_pkg::BEST_W-1:0]  rd_best,
    output      logic [mcc_pkg::IDX_W-1:0]   rd_last
);

    logic [mcc_pkg::BEST_W-1:0] best_mem [DEPTH];
    logic [mcc_pkg::IDX_W-1:0]  last_mem [DEPTH];

    // write port
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            best_mem[addr] <= wr_best;
            last_mem[addr] <= wr_last;
        end
    end

    // registered read, old data on a write cycle
    always_ff @(posedge aclk) begin
        rd_best <= best_mem[addr];
        rd_last <= last_mem[addr];
    end

endmodule

`default_nettype wire

/* src/min_coin_change_dp.sv */
// top level: minimum coin change by table fill and walk-back
//
// Configuration: a plain write port (cfg_wr_en, cfg_addr, cfg_wdata). Index 0 sets the
// number of denominations, indexes 1 to 6 the denomination values. Write only while idle.
// Input: one amount per beat on s_valid/s_ready. s_ready is high only while idle.
// Output: one beat per denomination in use on m_valid/m_ready, coin_index counting up
// from 0, last set on the final one; every beat carries min_coins and reachable.
// An unreachable amount skips the walk-back; amount zero skips both fill and walk-back.
// The fill loop makes one table read per denomination and one table write per
// amount, all through the single port of the table memory.
// An amount above MAX_AMOUNT skips the fill and reports unreachable.
// The next amount can be taken in the cycle after the last output beat is accepted.
// A stalled receiver holds the current output beat; nothing is lost.
// Reset (aresetn low, synchronous) returns to idle, sets one denomination of value 1
// and clears the tallies. The tables need no clearing: each amount rebuilds them.
`default_nettype none

module min_coin_change_dp #(
    parameter int MAX_AMOUNT = mcc_pkg::DEF_MAX_AMOUNT,
    parameter int NUM_COINS  = mcc_pkg::DEF_NUM_COINS
) (
    input  wire logic                             aclk,
    input  wire logic                             aresetn,
    // configuration
    input  wire logic                             cfg_wr_en,
    input  wire logic [mcc_pkg::CFG_ADDR_W-1:0]   cfg_addr,
    input  wire logic [mcc_pkg::COIN_W-1:0]       cfg_wdata,
    // input channel
    input  wire logic                             s_valid,
    output      logic                             s_ready,
    input  wire logic [mcc_pkg::COIN_W-1:0]       s_amount,
    // result channel
    output      logic                             m_valid,
    input  wire logic                             m_ready,
    output      logic [mcc_pkg::IDX_W-1:0]        m_coin_index,
    output      logic [mcc_pkg::COIN_W-1:0]       m_coin_used,
    output      logic [mcc_pkg::COIN_W-1:0]       m_min_coins,
    output      logic                             m_reachable,
    output      logic                             m_last
);

    localparam int DEPTH = MAX_AMOUNT + 1;
    localparam int AW    = $clog2(DEPTH);
    localparam int WW    = (AW > mcc_pkg::COIN_W) ? AW : mcc_pkg::COIN_W;
    localparam int TW    = (NUM_COINS > 1) ? $clog2(NUM_COINS) : 1;
    localparam int NLIM_I = (NUM_COINS < mcc_pkg::COIN_REGS) ? NUM_COINS : mcc_pkg::COIN_REGS;
    localparam logic [mcc_pkg::IDX_W-1:0] NLIM = mcc_pkg::IDX_W'(NLIM_I);

    localparam logic [mcc_pkg::BEST_W-1:0] BEST_ONE  = mcc_pkg::BEST_W'(1);
    localparam logic [mcc_pkg::BEST_W-1:0] BEST_ZERO = '0;

    // configuration registers
    logic [mcc_pkg::CNT_CFG_W-1:0] coin_count_reg;
    logic [mcc_pkg::COIN_W-1:0]    coin_reg [mcc_pkg::COIN_REGS];

    // sequencer and datapath registers
    mcc_pkg::state_t              state_reg, state_next;
    logic [AW-1:0]                amount_reg, amount_next;
    logic [AW-1:0]                x_reg, x_next;
    logic [mcc_pkg::IDX_W-1:0]    n_reg, n_next;
    logic [mcc_pkg::IDX_W-1:0]    i_reg, i_next;
    logic [mcc_pkg::IDX_W-1:0]    k_reg, k_next;
    logic                         pend_valid_reg, pend_valid_next;
    logic [mcc_pkg::IDX_W-1:0]    pend_idx_reg, pend_idx_next;
    logic [mcc_pkg::BEST_W-1:0]   best_reg, best_next;
    logic [mcc_pkg::IDX_W-1:0]    pick_reg, pick_next;
    logic [mcc_pkg::BEST_W-1:0]   total_reg, total_next;
    logic                         reach_reg, reach_next;
    logic [mcc_pkg::COIN_W-1:0]   tally_reg [NUM_COINS];

    // table port
    logic                         tbl_we;
    logic [AW-1:0]                tbl_addr;
    logic [mcc_pkg::BEST_W-1:0]   tbl_wr_best;
    logic [mcc_pkg::IDX_W-1:0]    tbl_wr_last;
    logic [mcc_pkg::BEST_W-1:0]   rd_best;
    logic [mcc_pkg::IDX_W-1:0]    rd_last;

    // shared helpers
    logic [mcc_pkg::IDX_W-1:0]    n_cfg;
    logic [mcc_pkg::IDX_W-1:0]    sel_idx;
    logic [mcc_pkg::COIN_W-1:0]   sel_coin;
    logic [WW-1:0]                sel_coin_ext;
    logic [WW-1:0]                cur_x_ext;
    logic                         coin_fits;
    logic                         exact_hit;
    logic [mcc_pkg::IDX_W-1:0]    exact_idx;
    logic                         cand_ok;
    logic [mcc_pkg::BEST_W-1:0]   cand_best;
    logic [mcc_pkg::BEST_W-1:0]   best_eval;
    logic [mcc_pkg::IDX_W-1:0]    pick_eval;
    logic [mcc_pkg::BEST_W-1:0]   fin_best;
    logic [mcc_pkg::IDX_W-1:0]    fin_pick;
    logic                         in_beat;
    logic                         out_beat;
    logic                         amount_big;
    logic                         tally_inc;
    logic                         tally_clr;

    assign in_beat  = s_valid && s_ready;
    assign out_beat = m_valid && m_ready;
    assign amount_big = (32'(s_amount) > MAX_AMOUNT);

    // configuration write port
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            coin_count_reg <= mcc_pkg::COIN_COUNT_RST;
            for (int r = 0; r < mcc_pkg::COIN_REGS; r++) begin
                coin_reg[r] <= mcc_pkg::COIN_VAL_RST;
            end
        end else if (cfg_wr_en) begin
            if (cfg_addr == mcc_pkg::REG_COIN_COUNT) begin
                coin_count_reg <= cfg_wdata[mcc_pkg::CNT_CFG_W-1:0];
            end else if (cfg_addr >= mcc_pkg::REG_COIN_FIRST &&
                         cfg_addr <= mcc_pkg::REG_COIN_LAST) begin
                coin_reg[cfg_addr - mcc_pkg::REG_COIN_FIRST] <= cfg_wdata;
            end
        end
    end

    // denominations in use, zero means one, capped at the build limit
    always_comb begin
        if (coin_count_reg == '0) begin
            n_cfg = mcc_pkg::IDX_W'(1);
        end else if (coin_count_reg > NLIM) begin
            n_cfg = NLIM;
        end else begin
            n_cfg = coin_count_reg;
        end
    end

    // one coin read port, fill index or walk-back index
    assign sel_idx = (state_reg == mcc_pkg::ST_WALK_EV) ? rd_last : i_reg;
    always_comb begin
        sel_coin = '0;
        for (int r = 0; r < mcc_pkg::COIN_REGS; r++) begin
            if (sel_idx == mcc_pkg::IDX_W'(r)) begin
                sel_coin = coin_reg[r];
            end
        end
    end
    assign sel_coin_ext = WW'(sel_coin);
    assign cur_x_ext    = WW'(x_reg);
    assign coin_fits    = (sel_coin != '0) && (sel_coin_ext <= cur_x_ext);

    // first denomination equal to the current amount
    always_comb begin
        exact_hit = 1'b0;
        exact_idx = '0;
        for (int r = 0; r < mcc_pkg::COIN_REGS; r++) begin
            if (!exact_hit && mcc_pkg::IDX_W'(r) < n_reg &&
                WW'(coin_reg[r]) == cur_x_ext) begin
                exact_hit = 1'b1;
                exact_idx = mcc_pkg::IDX_W'(r);
            end
        end
    end

    // compare unit: later coin wins a tie
    assign cand_best = rd_best + BEST_ONE;
    assign cand_ok   = pend_valid_reg && (rd_best != mcc_pkg::UNREACH) &&
                       (cand_best <= best_reg);
    assign best_eval = cand_ok ? cand_best : best_reg;
    assign pick_eval = cand_ok ? pend_idx_reg : pick_reg;
    assign fin_best  = exact_hit ? BEST_ONE : best_eval;
    assign fin_pick  = exact_hit ? exact_idx : pick_eval;

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            mcc_pkg::ST_IDLE: begin
                if (in_beat) begin
                    state_next = amount_big ? mcc_pkg::ST_OUT : mcc_pkg::ST_INIT;
                end
            end
            mcc_pkg::ST_INIT: begin
                state_next = (amount_reg == '0) ? mcc_pkg::ST_OUT : mcc_pkg::ST_FILL;
            end
            mcc_pkg::ST_FILL: begin
                if (i_reg == n_reg && x_reg == amount_reg) begin
                    state_next = (fin_best != mcc_pkg::UNREACH) ?
                                 mcc_pkg::ST_WALK_RD : mcc_pkg::ST_OUT;
                end
            end
            mcc_pkg::ST_WALK_RD: begin
                state_next = (x_reg == '0) ? mcc_pkg::ST_OUT : mcc_pkg::ST_WALK_EV;
            end
            mcc_pkg::ST_WALK_EV: begin
                if (rd_last >= n_reg || !coin_fits) begin
                    state_next = mcc_pkg::ST_OUT;
                end else begin
                    state_next = mcc_pkg::ST_WALK_RD;
                end
            end
            mcc_pkg::ST_OUT: begin
                if (out_beat && m_last) begin
                    state_next = mcc_pkg::ST_IDLE;
                end
            end
            default: state_next = mcc_pkg::ST_IDLE;
        endcase
    end

    // datapath and table control
    always_comb begin
        amount_next     = amount_reg;
        x_next          = x_reg;
        n_next          = n_reg;
        i_next          = i_reg;
        k_next          = k_reg;
        pend_valid_next = 1'b0;
        pend_idx_next   = i_reg;
        best_next       = best_reg;
        pick_next       = pick_reg;
        total_next      = total_reg;
        reach_next      = reach_reg;
        tbl_we          = 1'b0;
        tbl_addr        = x_reg;
        tbl_wr_best     = fin_best;
        tbl_wr_last     = fin_pick;
        tally_inc       = 1'b0;
        tally_clr       = 1'b0;
        unique case (state_reg)
            mcc_pkg::ST_IDLE: begin
                if (in_beat) begin
                    amount_next = AW'(s_amount);
                    n_next      = n_cfg;
                    k_next      = '0;
                    total_next  = '0;
                    reach_next  = 1'b0;
                    tally_clr   = 1'b1;
                end
            end
            mcc_pkg::ST_INIT: begin
                // amount zero takes no coins
                tbl_we      = 1'b1;
                tbl_addr    = '0;
                tbl_wr_best = BEST_ZERO;
                tbl_wr_last = '0;
                x_next      = AW'(1);
                i_next      = '0;
                best_next   = mcc_pkg::UNREACH;
                pick_next   = '0;
                reach_next  = (amount_reg == '0);
            end
            mcc_pkg::ST_FILL: begin
                if (i_reg != n_reg) begin
                    // issue a read for this coin, judge the previous one
                    tbl_addr        = AW'(cur_x_ext - sel_coin_ext);
                    pend_valid_next = coin_fits;
                    pend_idx_next   = i_reg;
                    best_next       = best_eval;
                    pick_next       = pick_eval;
                    i_next          = i_reg + mcc_pkg::IDX_W'(1);
                end else begin
                    // store the result for this amount
                    tbl_we    = 1'b1;
                    tbl_addr  = x_reg;
                    i_next    = '0;
                    best_next = mcc_pkg::UNREACH;
                    pick_next = '0;
                    if (x_reg == amount_reg) begin
                        reach_next = (fin_best != mcc_pkg::UNREACH);
                        total_next = (fin_best != mcc_pkg::UNREACH) ? fin_best : BEST_ZERO;
                    end else begin
                        x_next = x_reg + AW'(1);
                    end
                end
            end
            mcc_pkg::ST_WALK_RD: begin
                tbl_addr = x_reg;
            end
            mcc_pkg::ST_WALK_EV: begin
                if (rd_last < n_reg && coin_fits) begin
                    tally_inc = 1'b1;
                    x_next    = AW'(cur_x_ext - sel_coin_ext);
                end
            end
            mcc_pkg::ST_OUT: begin
                if (out_beat) begin
                    k_next = k_reg + mcc_pkg::IDX_W'(1);
                end
            end
            default: begin
            end
        endcase
    end

    // control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= mcc_pkg::ST_IDLE;
            k_reg          <= '0;
            i_reg          <= '0;
            n_reg          <= mcc_pkg::IDX_W'(1);
            pend_valid_reg <= 1'b0;
            reach_reg      <= 1'b0;
        end else begin
            state_reg      <= state_next;
            k_reg          <= k_next;
            i_reg          <= i_next;
            n_reg          <= n_next;
            pend_valid_reg <= pend_valid_next;
            reach_reg      <= reach_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        amount_reg   <= amount_next;
        x_reg        <= x_next;
        pend_idx_reg <= pend_idx_next;
        best_reg     <= best_next;
        pick_reg     <= pick_next;
        total_reg    <= total_next;
    end

    // per-denomination tallies
    always_ff @(posedge aclk) begin
        if (!aresetn || tally_clr) begin
            for (int t = 0; t < NUM_COINS; t++) begin
                tally_reg[t] <= '0;
            end
        end else if (tally_inc) begin
            tally_reg[rd_last[TW-1:0]] <= tally_reg[rd_last[TW-1:0]] + mcc_pkg::COIN_W'(1);
        end
    end

    // table memory
    mcc_table #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_table (
        .aclk    (aclk),
        .wr_en   (tbl_we),
        .addr    (tbl_addr),
        .wr_best (tbl_wr_best),
        .wr_last (tbl_wr_last),
        .rd_best (rd_best),
        .rd_last (rd_last)
    );

    // channel outputs
    assign s_ready      = (state_reg == mcc_pkg::ST_IDLE);
    assign m_valid      = (state_reg == mcc_pkg::ST_OUT);
    assign m_coin_index = k_reg;
    assign m_coin_used  = tally_reg[k_reg[TW-1:0]];
    assign m_min_coins  = total_reg[mcc_pkg::COIN_W-1:0];
    assign m_reachable  = reach_reg;
    assign m_last       = (k_reg + mcc_pkg::IDX_W'(1) == n_reg);

endmodule

`default_nettype wire

/* dv/tb_top.sv */
// testbench for the minimum coin change block: random and directed amounts, self-checking
`timescale 1ns / 100ps

module tb_top;

    localparam int MAX_AMT   = mcc_pkg::DEF_MAX_AMOUNT;
    localparam int MAX_COINS = mcc_pkg::DEF_NUM_COINS;
    localparam int NO_WAY    = -1;
    localparam int MAX_WAIT  = 11;
    localparam int DRAIN     = 40;
    localparam int ERR_PRINTS = 60;

    // writes to this index land beyond the register list
    localparam logic [mcc_pkg::CFG_ADDR_W-1:0] REG_BEYOND = mcc_pkg::REG_COIN_LAST + 3'd1;

    typedef logic [mcc_pkg::COIN_W-1:0] coin_arr_t [mcc_pkg::COIN_REGS];

    typedef struct {
        logic [mcc_pkg::IDX_W-1:0]  coin_index;
        logic [mcc_pkg::COIN_W-1:0] coin_used;
        logic [mcc_pkg::COIN_W-1:0] min_coins;
        logic                       reachable;
        logic                       last;
    } coin_beat_t;

    // clock, reset and block inputs, all known from time zero
    logic                           aclk;
    logic                           aresetn   = 1'b0;
    logic                           cfg_wr_en = 1'b0;
    logic [mcc_pkg::CFG_ADDR_W-1:0] cfg_addr  = '0;
    logic [mcc_pkg::COIN_W-1:0]     cfg_wdata = '0;
    logic                           s_valid   = 1'b0;
    logic                           s_ready;
    logic [mcc_pkg::COIN_W-1:0]     s_amount  = '0;
    logic                           m_valid;
    logic                           m_ready   = 1'b0;
    logic [mcc_pkg::IDX_W-1:0]      m_coin_index;
    logic [mcc_pkg::COIN_W-1:0]     m_coin_used;
    logic [mcc_pkg::COIN_W-1:0]     m_min_coins;
    logic                           m_reachable;
    logic                           m_last;

    // shadow of the configuration registers
    logic [mcc_pkg::CNT_CFG_W-1:0]  cur_count = mcc_pkg::COIN_COUNT_RST;
    logic [mcc_pkg::COIN_W-1:0]     cur_coin [mcc_pkg::COIN_REGS];

    // predictor tables
    int                    best_tab [0:MAX_AMT];
    int                    pick_tab [0:MAX_AMT];

    logic [mcc_pkg::COIN_W-1:0] amount_queue [$];
    coin_beat_t            change_due [$];

    int                    err_count = 0;
    longint                cycles    = 0;
    longint                wd_limit  = 20000;
    int                    send_gap  = 0;
    int                    recv_stall = 0;
    bit                    send_burst = 1'b0;
    bit                    recv_burst = 1'b0;

    min_coin_change_dp dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .cfg_wr_en    (cfg_wr_en),
        .cfg_addr     (cfg_addr),
        .cfg_wdata    (cfg_wdata),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_amount     (s_amount),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_coin_index (m_coin_index),
        .m_coin_used  (m_coin_used),
        .m_min_coins  (m_min_coins),
        .m_reachable  (m_reachable),
        .m_last       (m_last)
    );

    // 12 ns clock
    always begin
        aclk = 1'b1;
        #6;
        aclk = 1'b0;
        #6;
    end

    initial begin
        foreach (cur_coin[k]) cur_coin[k] = mcc_pkg::COIN_VAL_RST;
    end

    task automatic report_mismatch(input string what, input int got, input int want);
        err_count++;
        if (err_count <= ERR_PRINTS)
            $display("mismatch: %s got %0d want %0d (cycle %0d)", what, got, want, cycles);
    endtask

    // wait per beat, with stretches of back-to-back beats
    function automatic int draw_gap(inout bit burst);
        if ($urandom_range(0, 15) == 0) burst = !burst;
        return burst ? 0 : int'($urandom_range(0, MAX_WAIT));
    endfunction

    function automatic int coins_in_use();
        if (cur_count == 0) return 1;
        if (cur_count > MAX_COINS) return MAX_COINS;
        return int'(cur_count);
    endfunction

    // fewest-coin table fill and walk-back for one amount
    function automatic void predict_change(input logic [mcc_pkg::COIN_W-1:0] amt);
        int                         n;
        int                         x;
        int                         k;
        int                         c;
        int                         bst;
        int                         pk;
        int                         sub;
        bit                         exact;
        bit                         reach;
        logic [mcc_pkg::COIN_W-1:0] total;
        logic [mcc_pkg::COIN_W-1:0] tally [mcc_pkg::COIN_REGS];
        coin_beat_t                 beat;
        n = coins_in_use();
        reach = 1'b0;
        total = '0;
        foreach (tally[j]) tally[j] = '0;
        best_tab[0] = 0;
        pick_tab[0] = 0;
        for (x = 1; x <= int'(amt); x++) begin
            bst = NO_WAY;
            pk = 0;
            exact = 1'b0;
            // a coin equal to the value takes it alone, first match wins
            for (k = 0; k < n; k++) begin
                if (!exact && int'(cur_coin[k]) == x) begin
                    bst = 1;
                    pk = k;
                    exact = 1'b1;
                end
            end
            // otherwise try every coin that fits, later coin wins a tie
            if (!exact) begin
                for (k = 0; k < n; k++) begin
                    c = int'(cur_coin[k]);
                    if (c != 0 && c <= x) begin
                        sub = best_tab[x - c];
                        if (sub != NO_WAY && (bst == NO_WAY || sub + 1 <= bst)) begin
                            bst = sub + 1;
                            pk = k;
                        end
                    end
                end
            end
            best_tab[x] = bst;
            pick_tab[x] = pk;
        end
        // walk back through the last-coin table
        if (best_tab[amt] != NO_WAY) begin
            reach = 1'b1;
            total = mcc_pkg::COIN_W'(best_tab[amt]);
            x = int'(amt);
            while (x > 0) begin
                k = pick_tab[x];
                if (k >= n) break;
                c = int'(cur_coin[k]);
                if (c == 0 || c > x) break;
                tally[k] = tally[k] + 1'b1;
                x = x - c;
            end
        end
        for (k = 0; k < n; k++) begin
            beat.coin_index = mcc_pkg::IDX_W'(k);
            beat.coin_used  = reach ? tally[k] : '0;
            beat.min_coins  = reach ? total : '0;
            beat.reachable  = reach;
            beat.last       = (k + 1 == n);
            change_due.push_back(beat);
        end
    endfunction

    // input driver
    always @(posedge aclk) begin : drive_amounts
        logic                       fire;
        logic                       nxt_valid;
        logic [mcc_pkg::COIN_W-1:0] nxt_amt;
        fire = s_valid && s_ready;
        nxt_valid = s_valid && !fire;
        nxt_amt = s_amount;
        if (fire) begin
            predict_change(s_amount);
            send_gap = draw_gap(send_burst);
        end
        if (aresetn && !nxt_valid) begin
            if (send_gap > 0) begin
                send_gap--;
            end else if (amount_queue.size() > 0) begin
                nxt_valid = 1'b1;
                nxt_amt = amount_queue.pop_front();
            end
        end
        s_valid <= nxt_valid;
        s_amount <= nxt_amt;
    end

    // result monitor and receiver stalls
    always @(posedge aclk) begin : take_results
        coin_beat_t want;
        if (m_valid && m_ready) begin
            if (change_due.size() == 0) begin
                report_mismatch("beat with nothing expected, coin_index", m_coin_index, 0);
            end else begin
                want = change_due.pop_front();
                if (m_coin_index !== want.coin_index)
                    report_mismatch("coin_index", m_coin_index, want.coin_index);
                if (m_coin_used !== want.coin_used)
                    report_mismatch("coin_used", m_coin_used, want.coin_used);
                if (m_min_coins !== want.min_coins)
                    report_mismatch("min_coins", m_min_coins, want.min_coins);
                if (m_reachable !== want.reachable)
                    report_mismatch("reachable", m_reachable, want.reachable);
                if (m_last !== want.last)
                    report_mismatch("last", m_last, want.last);
            end
            recv_stall = draw_gap(recv_burst);
        end
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (recv_stall > 0) begin
            recv_stall--;
            m_ready <= 1'b0;
        end else begin
            m_ready <= 1'b1;
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycles++;
        if (cycles > wd_limit) begin
            $display("timeout after %0d cycles", cycles);
            $display("FAILURE");
            $finish;
        end
    end

    // queue one amount and widen the watchdog by its worst-case cost
    task automatic queue_amount(input logic [mcc_pkg::COIN_W-1:0] amt);
        amount_queue.push_back(amt);
        wd_limit += 4 * (20 + longint'(amt) * (coins_in_use() + 3)
                         + MAX_COINS * (MAX_WAIT + 2) + MAX_WAIT + 2);
    endtask

    // wait until every queued amount is answered, then let the block go idle
    task automatic settle();
        while (amount_queue.size() != 0 || s_valid || change_due.size() != 0)
            @(negedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    // write count and all denominations, optionally poke the unused index
    task automatic set_coins(input logic [mcc_pkg::CNT_CFG_W-1:0] cnt, input coin_arr_t vals,
                             input bit poke_beyond);
        @(posedge aclk);
        cfg_wr_en <= 1'b1;
        cfg_addr  <= mcc_pkg::REG_COIN_COUNT;
        cfg_wdata <= mcc_pkg::COIN_W'(cnt);
        cur_count = cnt;
        for (int k = 0; k < mcc_pkg::COIN_REGS; k++) begin
            @(posedge aclk);
            cfg_addr  <= mcc_pkg::REG_COIN_FIRST + mcc_pkg::CFG_ADDR_W'(k);
            cfg_wdata <= vals[k];
            cur_coin[k] = vals[k];
        end
        if (poke_beyond) begin
            @(posedge aclk);
            cfg_addr  <= REG_BEYOND;
            cfg_wdata <= '1;
        end
        @(posedge aclk);
        cfg_wr_en <= 1'b0;
        wd_limit += 100;
    endtask

    // stimulus
    initial begin : stimulus
        coin_arr_t                  vals;
        int                         mode;
        int                         step;
        logic [mcc_pkg::COIN_W-1:0] amt;
        repeat (12) @(posedge aclk);
        aresetn <= 1'b1;

        // reset values: one coin of value 1
        queue_amount(10'd0);
        queue_amount(10'd1);
        queue_amount(10'd1023);
        queue_amount(10'd5);
        settle();

        // six sorted coins, exact matches and the largest amount
        set_coins(3'd6, '{10'd1, 10'd5, 10'd10, 10'd25, 10'd50, 10'd100}, 1'b0);
        queue_amount(10'd0);
        queue_amount(10'd30);
        queue_amount(10'd100);
        queue_amount(10'd1023);
        queue_amount(10'd999);
        settle();

        // no coin of value 1: unreachable amounts and ties
        set_coins(3'd3, '{10'd4, 10'd6, 10'd9, 10'd1, 10'd1, 10'd1}, 1'b0);
        queue_amount(10'd1);
        queue_amount(10'd5);
        queue_amount(10'd10);
        queue_amount(10'd11);
        queue_amount(10'd12);
        queue_amount(10'd13);
        settle();

        // zero count means one coin; a single largest coin
        set_coins(3'd0, '{10'd1023, 10'd2, 10'd3, 10'd4, 10'd5, 10'd6}, 1'b0);
        queue_amount(10'd1023);
        queue_amount(10'd1022);
        queue_amount(10'd0);
        settle();

        // count above the limit, zero coins, unsorted values, write past the list
        set_coins(3'd7, '{10'd0, 10'd7, 10'd3, 10'd1023, 10'd0, 10'd2}, 1'b1);
        queue_amount(10'd0);
        queue_amount(10'd1);
        queue_amount(10'd5);
        queue_amount(10'd1023);
        settle();

        // random phases
        for (int ph = 0; ph < 8; ph++) begin
            mode = $urandom_range(0, 9);
            for (int k = 0; k < mcc_pkg::COIN_REGS; k++) begin
                if (mode <= 6) begin
                    // ascending small coins, duplicates allowed
                    step = (k == 0) ? $urandom_range(1, 4) : $urandom_range(0, 12);
                    vals[k] = (k == 0) ? mcc_pkg::COIN_W'(step)
                            : vals[k-1] + mcc_pkg::COIN_W'(step);
                end else if (mode == 7) begin
                    vals[k] = mcc_pkg::COIN_W'($urandom_range(0, 1023));
                end else if (mode == 8) begin
                    // ascending with a wide spread up to the top value
                    vals[k] = (k == 0) ? mcc_pkg::COIN_W'($urandom_range(1, 3))
                            : vals[k-1]
                              + mcc_pkg::COIN_W'($urandom_range(0, 1023 - vals[k-1]));
                end else begin
                    vals[k] = mcc_pkg::COIN_W'($urandom_range(0, 15));
                end
            end
            set_coins(mcc_pkg::CNT_CFG_W'($urandom_range(0, 7)), vals,
                      $urandom_range(0, 3) == 0);
            for (int i = 0; i < 10; i++) begin
                step = $urandom_range(0, 99);
                // mostly small amounts, a few large ones to reach the top of the table
                if (step < 85)
                    amt = mcc_pkg::COIN_W'($urandom_range(0, 127));
                else if (step < 95)
                    amt = mcc_pkg::COIN_W'($urandom_range(0, 400));
                else
                    amt = mcc_pkg::COIN_W'($urandom_range(0, 1023));
                queue_amount(amt);
            end
            settle();
        end

        repeat (DRAIN) @(posedge aclk);
        if (change_due.size() != 0)
            report_mismatch("results never delivered", 0, change_due.size());
        if (err_count == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

/* files.f */
src/mcc_pkg.sv
src/mcc_table.sv
src/min_coin_change_dp.sv
dv/tb_top.sv
